@@ rtl/running_mean_stddev_zscore_macros.svh @@
// Assertion macros of the running statistics block, included by rmsz_back.
// Every use sits inside a module that has clk and rst.
`ifndef RUNNING_MEAN_STDDEV_ZSCORE_MACROS_SVH
`define RUNNING_MEAN_STDDEV_ZSCORE_MACROS_SVH
`ifndef SYNTHESIS
`define RMSZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rmsz assertion failed");
`define RMSZ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rmsz assertion failed");
`else
`define RMSZ_ASSERT(lbl, prop)
`define RMSZ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/rmsz_pkg.sv @@
// Types, codes and widths of the running mean / std-dev / z-score block.
// No dependencies; every other RTL file imports it.
package rmsz_pkg;

  localparam int MAX_CHANNELS = 128;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int SAMPLE_W     = 24;
  localparam int FRAC_W       = 16;
  localparam int MEAN_W       = SAMPLE_W + FRAC_W;   // Q24.16
  localparam int DELTA_W      = MEAN_W + 1;
  localparam int M2_W         = 64;
  localparam int SD_W         = 40;
  localparam int Z_W          = 32;
  localparam int CNT_W        = 32;
  localparam int ACT_W        = 8;
  localparam int QDEPTH       = 2;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_ZSCORE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FEW   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_ACTIVE_CHANNELS = 1'b0,
    CFG_ZERO_WHEN_FLAT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_DIVM, S_NM, S_MUL, S_WR, S_DIVV, S_SQRT, S_DIVZ, S_OUT
  } bstate_t;

  // one classified item as it waits between front and back
  typedef struct packed {
    mode_t                      mode;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       in_range;
  } item_t;

  function automatic logic [DELTA_W-1:0] mag41(logic signed [DELTA_W-1:0] v);
    return v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
  endfunction

endpackage

@@ rtl/rmsz_if.sv @@
// Valid/ready channel interfaces for item input and result output.
// Depends on rmsz_pkg.
interface rmsz_in_if;
  import rmsz_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_of_set;
  modport source (output valid, mode, channel, sample_value, last_of_set, input ready);
  modport sink   (input valid, mode, channel, sample_value, last_of_set, output ready);
endinterface

interface rmsz_out_if;
  import rmsz_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [CH_W-1:0]          out_channel;
  logic signed [MEAN_W-1:0] mean_value;
  logic [SD_W-1:0]          std_dev;
  logic signed [Z_W-1:0]    zscore;
  modport source (output valid, status, out_channel, mean_value, std_dev, zscore,
                  input ready);
  modport sink   (input valid, status, out_channel, mean_value, std_dev, zscore,
                  output ready);
endinterface

@@ rtl/rmsz_front.sv @@
// Front end: accepts items, checks the channel range and queues them.
// Depends on rmsz_pkg and rmsz_in_if.
module rmsz_front (
  input  logic                         clk,
  input  logic                         rst,
  rmsz_in_if.sink                      in_ch,
  input  logic [rmsz_pkg::ACT_W-1:0]   active_channels,
  input  logic                         pop,
  output logic                         q_valid,
  output rmsz_pkg::item_t              head
);
  import rmsz_pkg::*;

  localparam logic [ACT_W-1:0] CHAN_LIMIT = ACT_W'(MAX_CHANNELS);

  item_t      entry [QDEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push;
  item_t      incoming;

  assign in_ch.ready = (fill != 2'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != 2'd0);
  assign head        = entry[rd_ptr];

  always_comb begin
    incoming.mode     = mode_t'(in_ch.mode);
    incoming.channel  = in_ch.channel;
    incoming.sample   = in_ch.sample_value;
    incoming.last     = in_ch.last_of_set;
    incoming.in_range = ({1'b0, in_ch.channel} < active_channels) &&
                        ({1'b0, in_ch.channel} < CHAN_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/rmsz_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on rmsz_pkg.
module rmsz_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rmsz_pkg::M2_W-1:0]   dividend,
  input  logic [rmsz_pkg::SD_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [rmsz_pkg::M2_W-1:0]   quotient
);
  import rmsz_pkg::*;

  localparam int CW = $clog2(M2_W + 1);

  logic [SD_W-1:0] dvsr, rem;
  logic [M2_W-1:0] quo;
  logic [CW-1:0]   cnt;
  logic [SD_W:0]   shifted, diff;
  logic            fits;

  assign shifted  = {rem, quo[M2_W-1]};
  assign diff     = shifted - {1'b0, dvsr};
  assign fits     = (shifted >= {1'b0, dvsr});
  assign done     = busy && (cnt == '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy && cnt != '0) begin
      rem <= fits ? diff[SD_W-1:0] : shifted[SD_W-1:0];
      quo <= {quo[M2_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(M2_W);
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/rmsz_mul.sv @@
// Shift-add multiplier for the two 41-bit deviation magnitudes.
// Depends on rmsz_pkg.
module rmsz_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rmsz_pkg::DELTA_W-1:0]    a,
  input  logic [rmsz_pkg::DELTA_W-1:0]    b,
  output logic                            done,
  output logic [2*rmsz_pkg::DELTA_W-1:0]  product
);
  import rmsz_pkg::*;

  localparam int PW = 2 * DELTA_W;
  localparam int CW = $clog2(DELTA_W + 1);

  logic [PW-1:0]      acc, mcand;
  logic [DELTA_W-1:0] mplier;
  logic [CW-1:0]      cnt;
  logic               busy;

  assign done    = busy && (cnt == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PW'(a);
      mplier <= b;
    end else if (busy && cnt != '0) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= {mcand[PW-2:0], 1'b0};
      mplier <= {1'b0, mplier[DELTA_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DELTA_W);
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/rmsz_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on rmsz_pkg.
module rmsz_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [2*rmsz_pkg::SD_W-1:0]       radicand,
  output logic                              done,
  output logic [rmsz_pkg::SD_W-1:0]         root
);
  import rmsz_pkg::*;

  localparam int RW = 2 * SD_W;
  localparam int CW = $clog2(SD_W + 1);

  logic [RW-1:0]   rad;
  logic [SD_W+1:0] rem;
  logic [SD_W+2:0] r2, trial, diff;
  logic [SD_W-1:0] rt;
  logic [CW-1:0]   cnt;
  logic            busy, fits;

  assign r2    = {rem[SD_W:0], rad[RW-1:RW-2]};
  assign trial = {1'b0, rt, 2'b01};
  assign diff  = r2 - trial;
  assign fits  = (r2 >= trial);
  assign done  = busy && (cnt == '0);
  assign root  = rt;

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      rt  <= '0;
    end else if (busy && cnt != '0) begin
      rad <= {rad[RW-3:0], 2'b00};
      rem <= fits ? diff[SD_W+1:0] : r2[SD_W+1:0];
      rt  <= {rt[SD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(SD_W);
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/rmsz_back.sv @@
// Back end: channel stores, set counter, sequencer over divider, multiplier
// and square root, and the result register. Depends on rmsz_pkg, rmsz_div,
// rmsz_mul, rmsz_sqrt, rmsz_out_if and the assertion macros.
`include "running_mean_stddev_zscore_macros.svh"
module rmsz_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  rmsz_pkg::item_t         head,
  output logic                    pop,
  input  logic                    zero_when_flat,
  rmsz_out_if.source              out_ch
);
  import rmsz_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [Z_W-1:0]   Z_POS   = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic [Z_W-1:0]   Z_NEG   = {1'b1, {(Z_W-1){1'b0}}};

  logic [MEAN_W-1:0] mean_mem [MAX_CHANNELS];
  logic [M2_W-1:0]   m2_mem   [MAX_CHANNELS];

  bstate_t state, state_next;
  item_t   cur;

  logic        [CNT_W-1:0]   set_count;
  logic signed [MEAN_W-1:0]  mean_rd, nm_r;
  logic        [M2_W-1:0]    m2_rd, m2_new;
  logic signed [DELTA_W-1:0] delta_r;

  logic        [1:0]         res_status;
  logic signed [MEAN_W-1:0]  res_mean;
  logic        [SD_W-1:0]    res_std;
  logic signed [Z_W-1:0]     res_z;

  // unit handshakes
  logic                div_start, div_busy, div_done, mul_start, mul_done;
  logic                sqrt_start, sqrt_done;
  logic [M2_W-1:0]     div_a, div_q;
  logic [SD_W-1:0]     div_b, root;
  logic [2*DELTA_W-1:0] prod;
  logic                mem_we, out_load;

  logic signed [MEAN_W-1:0]  x;
  logic is_clear, is_upd, bad, quick, zero_cnt, few;
  logic [CNT_W-1:0]          count_inc;
  logic signed [DELTA_W-1:0] nm41, delta2, qs, delta_now;
  logic [M2_W-1:0]           inc;
  logic [M2_W:0]             m2_sum;
  logic [Z_W-1:0]            z_sat, z_flat;
  logic [MEAN_W-1:0]         wr_mean;
  logic [M2_W-1:0]           wr_m2;

  assign x         = {cur.sample, {FRAC_W{1'b0}}};
  assign is_clear  = (cur.mode == MODE_CLEAR);
  assign is_upd    = (cur.mode == MODE_UPDATE);
  assign bad       = !cur.in_range;
  assign zero_cnt  = (set_count == '0);
  assign few       = (set_count <= CNT_W'(1));
  assign quick     = is_clear || bad || (is_upd && zero_cnt) || (!is_upd && few);
  assign count_inc = (set_count == CNT_MAX) ? set_count : set_count + 1'b1;

  // first deviation, live in S_EVAL so the divider can start on it
  assign delta_now = $signed({x[MEAN_W-1], x}) - $signed({mean_rd[MEAN_W-1], mean_rd});

  // mean step with truncation toward zero, then the second deviation
  assign qs     = delta_r[DELTA_W-1] ? -$signed(div_q[DELTA_W-1:0])
                                     : $signed(div_q[DELTA_W-1:0]);
  assign nm41   = $signed({mean_rd[MEAN_W-1], mean_rd}) + qs;
  assign delta2 = $signed({x[MEAN_W-1], x}) - $signed({nm_r[MEAN_W-1], nm_r});

  assign inc    = (prod[2*DELTA_W-1:M2_W+FRAC_W] != '0) ? '1
                                                         : prod[M2_W+FRAC_W-1:FRAC_W];
  assign m2_sum = {1'b0, m2_rd} + {1'b0, inc};

  always_comb begin
    if (!delta_r[DELTA_W-1])
      z_sat = (div_q > M2_W'(Z_POS)) ? Z_POS : div_q[Z_W-1:0];
    else
      z_sat = (div_q > M2_W'(Z_NEG)) ? Z_NEG : Z_W'(-div_q[Z_W-1:0]);
    if (zero_when_flat)
      z_flat = '0;
    else
      z_flat = delta_r[DELTA_W-1] ? Z_NEG : Z_POS;
  end

  // divider operands: mean step, variance or z-score
  always_comb begin
    div_a = {(M2_W-DELTA_W)'(0), mag41(delta_now)};
    div_b = SD_W'({1'b0, set_count} + 1'b1);
    if (state == S_EVAL && !is_upd) begin
      div_a = m2_rd;
      div_b = SD_W'(set_count - 1'b1);
    end else if (state == S_SQRT) begin
      div_a = {(M2_W-DELTA_W-FRAC_W)'(0), mag41(delta_r), {FRAC_W{1'b0}}};
      div_b = root;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid) state_next = S_EVAL;
      S_EVAL: state_next = quick ? S_OUT : (is_upd ? S_DIVM : S_DIVV);
      S_DIVM: if (div_done) state_next = S_NM;
      S_NM:   state_next = S_MUL;
      S_MUL:  if (mul_done) state_next = S_WR;
      S_WR:   state_next = S_OUT;
      S_DIVV: if (div_done) state_next = S_SQRT;
      S_SQRT: begin
        if (sqrt_done)
          state_next = (cur.mode == MODE_ZSCORE && root != '0) ? S_DIVZ : S_OUT;
      end
      S_DIVZ: if (div_done) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop        = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    wr_mean    = nm_r;
    wr_m2      = m2_new;
    unique case (state)
      S_IDLE: pop = q_valid;
      S_EVAL: begin
        div_start = !quick;
        if (is_upd && !bad && zero_cnt) begin
          mem_we  = 1'b1;
          wr_mean = x;
          wr_m2   = '0;
        end
      end
      S_NM:   mul_start = 1'b1;
      S_WR:   mem_we = 1'b1;
      S_DIVV: sqrt_start = div_done;
      S_SQRT: div_start = sqrt_done && cur.mode == MODE_ZSCORE && root != '0;
      S_OUT:  out_load = !out_ch.valid || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mean_mem[cur.channel] <= wr_mean;
      m2_mem[cur.channel]   <= wr_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mean_rd <= mean_mem[head.channel];
      m2_rd   <= m2_mem[head.channel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_count <= '0;
    end else if (state == S_EVAL) begin
      if (is_clear)
        set_count <= '0;
      else if (is_upd && cur.last && (bad || zero_cnt))
        set_count <= count_inc;
    end else if (state == S_WR && cur.last) begin
      set_count <= count_inc;
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    unique case (state)
      S_EVAL: begin
        delta_r    <= delta_now;
        res_status <= is_clear ? STATUS_OK : bad ? STATUS_RANGE :
                      (!is_upd && few) ? STATUS_FEW : STATUS_OK;
        res_mean   <= (is_upd && !bad && !is_clear && zero_cnt) ? x : '0;
        res_std    <= '0;
        res_z      <= '0;
      end
      S_DIVM: if (div_done) nm_r <= nm41[MEAN_W-1:0];
      S_MUL:  if (mul_done) m2_new <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
      S_WR:   res_mean <= nm_r;
      S_SQRT: begin
        if (sqrt_done) begin
          res_mean <= mean_rd;
          res_std  <= root;
          res_z    <= (cur.mode == MODE_ZSCORE) ? z_flat : '0;
        end
      end
      S_DIVZ: if (div_done) res_z <= z_sat;
      default: ;
    endcase
  end

  rmsz_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  rmsz_mul u_mul (
    .clk, .rst, .start(mul_start), .a(mag41(delta_r)), .b(mag41(delta2)),
    .done(mul_done), .product(prod)
  );

  rmsz_sqrt u_sqrt (
    .clk, .rst, .start(sqrt_start), .radicand({div_q, {FRAC_W{1'b0}}}),
    .done(sqrt_done), .root(root)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (out_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.status      <= res_status;
      out_ch.out_channel <= cur.channel;
      out_ch.mean_value  <= res_mean;
      out_ch.std_dev     <= res_std;
      out_ch.zscore      <= res_z;
    end
  end

  `RMSZ_ASSERT(a_div_free, div_start |-> !div_busy)
  `RMSZ_ASSERT(a_mem_we_legal, mem_we |-> (cur.in_range && cur.mode == MODE_UPDATE))
  `RMSZ_ASSERT(a_range_zero, (out_load && res_status == STATUS_RANGE) |-> (res_mean == '0 && res_z == '0))
  `RMSZ_ASSERT(a_count_grows, (state != S_EVAL || !is_clear) |=> (set_count >= $past(set_count)))
  `RMSZ_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_ch.valid))

endmodule

@@ rtl/running_mean_stddev_zscore.sv @@
// Top level: configuration registers, front queue and back sequencer.
// Depends on rmsz_pkg, rmsz_if, rmsz_front and rmsz_back.
//
//  port     | dir | handshake   | beat carries
//  in_ch    | in  | valid/ready | mode, channel, sample_value, last_of_set
//  out_ch   | out | valid/ready | status, out_channel, mean_value, std_dev, zscore
//  cfg_*    | in  | cfg_we      | cfg_index, cfg_data
//
// One item at a time in the back end: clear, out-of-range, first update and
// too-few-sets items go straight to output; an update uses the divider, then
// the multiplier; a query the divider, then the square root; a z-score adds
// the divider again if the root is nonzero. A two-beat queue takes input
// while the back end works; a stalled result holds the back end in S_OUT.
// Reset is synchronous; the channel stores need no clear.
module running_mean_stddev_zscore (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [rmsz_pkg::ACT_W-1:0]  cfg_data,
  rmsz_in_if.sink                     in_ch,
  rmsz_out_if.source                  out_ch
);
  import rmsz_pkg::*;

  logic [ACT_W-1:0] active_channels;
  logic             zero_when_flat;
  logic             q_valid, pop;
  item_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= ACT_W'(MAX_CHANNELS);
      zero_when_flat  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_CHANNELS: active_channels <= cfg_data;
        CFG_ZERO_WHEN_FLAT:  zero_when_flat  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rmsz_front u_front (
    .clk, .rst, .in_ch, .active_channels, .pop, .q_valid, .head
  );

  rmsz_back u_back (
    .clk, .rst, .q_valid, .head, .pop, .zero_when_flat, .out_ch
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for running_mean_stddev_zscore: per-channel Welford stats and z-scores.
// Depends on rmsz_pkg, the rmsz_in_if / rmsz_out_if interfaces and the top-level RTL.
// Results are predicted per accepted beat and compared in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmsz_pkg::*;

  typedef struct {
    mode_t                      mode;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } beat_t;

  typedef struct {
    status_t         status;
    logic [CH_W-1:0] channel;
    logic [39:0]     mean;
    logic [39:0]     sd;
    logic [31:0]     z;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_ACTIVE_CHANNELS;
  logic [ACT_W-1:0] cfg_data = '0;

  rmsz_in_if  in_bus();
  rmsz_out_if out_bus();

  running_mean_stddev_zscore u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_bus.sink), .out_ch(out_bus.source)
  );

  always #2 clk = ~clk;

  // predictor state
  longint      chan_mean[MAX_CHANNELS];
  bit [63:0]   chan_m2[MAX_CHANNELS];
  bit [31:0]   sets_seen;
  int          active_cfg = 128;
  bit          flat_zero = 1'b1;

  beat_t  pending_beats[$];
  stats_t expected_stats[$];
  int     errors = 0;
  bit     quiet = 1'b0;
  bit     took_in = 1'b0;

  // stimulus-side shadow so no never-written entry is read
  bit        written[MAX_CHANNELS];
  bit [31:0] gen_sets;
  int        set_width;
  int        flat_val[MAX_CHANNELS];

  function automatic bit [63:0] absv(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic stats_t fold_beat(beat_t b);
    stats_t r;
    longint x, delta, nm, delta2, diff;
    bit [127:0] prod, target, sq;
    bit [63:0] inc, var_v, q;
    bit [64:0] sum;
    bit [39:0] sd, c;
    int k;
    x = longint'(b.sample) * 65536;
    r.status = STATUS_OK; r.channel = b.channel; r.mean = '0; r.sd = '0; r.z = '0;
    if (b.mode == MODE_CLEAR) begin
      sets_seen = 0;
    end else if (int'(b.channel) >= active_cfg) begin
      r.status = STATUS_RANGE;
    end else if (b.mode == MODE_UPDATE) begin
      if (sets_seen == 0) begin
        chan_mean[b.channel] = x;
        chan_m2[b.channel] = '0;
      end else begin
        delta = x - chan_mean[b.channel];
        nm = chan_mean[b.channel] + delta / (longint'(sets_seen) + 1);
        delta2 = x - nm;
        prod = 128'(absv(delta)) * 128'(absv(delta2));
        inc = (prod[127:80] != 0) ? '1 : prod[79:16];
        sum = {1'b0, chan_m2[b.channel]} + {1'b0, inc};
        chan_m2[b.channel] = sum[64] ? '1 : sum[63:0];
        chan_mean[b.channel] = nm;
      end
      r.mean = chan_mean[b.channel][39:0];
    end else if (sets_seen <= 1) begin
      r.status = STATUS_FEW;
    end else begin
      var_v = chan_m2[b.channel] / (64'(sets_seen) - 1);
      target = {48'b0, var_v, 16'b0};
      sd = '0;
      for (k = 39; k >= 0; k--) begin
        c = sd | (40'd1 << k);
        sq = 128'(c) * 128'(c);
        if (sq <= target) sd = c;
      end
      r.mean = chan_mean[b.channel][39:0];
      r.sd = sd;
      if (b.mode == MODE_ZSCORE) begin
        diff = x - chan_mean[b.channel];
        if (sd == 0) begin
          if (flat_zero) r.z = '0;
          else r.z = diff < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          q = (absv(diff) << 16) / 64'(sd);
          if (diff >= 0) r.z = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
          else r.z = q > 64'h8000_0000 ? 32'h8000_0000 : -q[31:0];
        end
      end
    end
    if (b.mode == MODE_UPDATE && b.last && sets_seen != '1) sets_seen++;
    return r;
  endfunction

  // queue a beat, first rewriting any that would read a never-written entry
  task automatic add_beat(mode_t md, int ch, int s, bit last);
    beat_t b;
    bit in_rng, reads;
    in_rng = ch < active_cfg;
    reads = in_rng && ((md == MODE_UPDATE && gen_sets != 0) ||
            ((md == MODE_ZSCORE || md == MODE_QUERY) && gen_sets > 1));
    if (reads && !written[ch]) begin
      if (active_cfg < MAX_CHANNELS) ch = $urandom_range(MAX_CHANNELS - 1, active_cfg);
      else md = MODE_CLEAR;
      in_rng = ch < active_cfg;
    end
    if (md == MODE_UPDATE && in_rng && gen_sets == 0) written[ch] = 1'b1;
    if (md == MODE_UPDATE && last && gen_sets != '1) gen_sets++;
    if (md == MODE_CLEAR) gen_sets = 0;
    b.mode = md; b.channel = CH_W'(ch); b.sample = SAMPLE_W'(s); b.last = last;
    pending_beats.push_back(b);
  endtask

  function automatic int pick_sample(int ch);
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 8388607 : -8388608;
      1: return flat_val[ch];
      default: return int'($urandom_range(16777215)) - 8388608;
    endcase
  endfunction

  task automatic write_cfg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= ACT_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE_CHANNELS) active_cfg = val;
    else flat_zero = val[0];
  endtask

  // wait until nothing is queued, offered or awaiting its result
  task automatic drain;
    while (pending_beats.size() != 0 || expected_stats.size() != 0 || in_bus.valid)
      @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    int cnt, ch, k;
    cnt = 0;
    while (cnt < n_items) begin
      k = $urandom_range(99);
      if (k < 8) begin
        add_beat(MODE_CLEAR, $urandom_range(127), pick_sample(0), 1'($urandom_range(1)));
        set_width = $urandom_range(active_cfg < 8 ? active_cfg : 8, 1);
        cnt++;
      end else if (k < 20) begin
        add_beat(mode_t'($urandom_range(3)), $urandom_range(127),
                 int'($urandom_range(16777215)) - 8388608, 1'($urandom_range(1)));
        cnt++;
      end else if (k < 60) begin
        for (ch = 0; ch < set_width; ch++)
          add_beat(MODE_UPDATE, ch, pick_sample(ch), ch == set_width - 1);
        cnt += set_width;
      end else begin
        ch = $urandom_range(set_width - 1);
        add_beat($urandom_range(1) ? MODE_ZSCORE : MODE_QUERY, ch, pick_sample(ch), 1'b0);
        cnt++;
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= quiet || $urandom_range(99) >= 32;
      if (!in_bus.valid || took_in) begin
        if (pending_beats.size() != 0 && (quiet || $urandom_range(99) >= 32)) begin
          in_bus.mode <= pending_beats[0].mode;
          in_bus.channel <= pending_beats[0].channel;
          in_bus.sample_value <= pending_beats[0].sample;
          in_bus.last_of_set <= pending_beats[0].last;
          in_bus.valid <= 1'b1;
          void'(pending_beats.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    beat_t b;
    stats_t e;
    took_in = 1'b0;
    if (!rst && in_bus.valid && in_bus.ready) begin
      took_in = 1'b1;
      b.mode = mode_t'(in_bus.mode); b.channel = in_bus.channel;
      b.sample = in_bus.sample_value; b.last = in_bus.last_of_set;
      expected_stats.push_back(fold_beat(b));
    end
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result beat ch=%0d", $time, out_bus.out_channel);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (out_bus.status !== e.status || out_bus.out_channel !== e.channel ||
            out_bus.mean_value !== e.mean || out_bus.std_dev !== e.sd ||
            out_bus.zscore !== e.z) begin
          $display("%0t: mismatch exp st=%0d ch=%0d mean=%h sd=%h z=%h", $time,
                   e.status, e.channel, e.mean, e.sd, e.z);
          $display("%0t:          got st=%0d ch=%0d mean=%h sd=%h z=%h", $time,
                   out_bus.status, out_bus.out_channel, out_bus.mean_value,
                   out_bus.std_dev, out_bus.zscore);
          errors++;
        end
      end
    end
  end

  initial begin
    int i, tries;
    in_bus.valid = 1'b0; in_bus.mode = '0; in_bus.channel = '0;
    in_bus.sample_value = '0; in_bus.last_of_set = 1'b0; out_bus.ready = 1'b0;
    sets_seen = 0; gen_sets = 0; set_width = 4;
    for (i = 0; i < MAX_CHANNELS; i++) begin
      chan_mean[i] = 0; chan_m2[i] = '0; written[i] = 1'b0;
      flat_val[i] = int'($urandom_range(16777215)) - 8388608;
    end
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: too few sets, extremes, flat channel
    write_cfg(CFG_ACTIVE_CHANNELS, 128);
    write_cfg(CFG_ZERO_WHEN_FLAT, 1);
    add_beat(MODE_ZSCORE, 0, 0, 1'b1);
    add_beat(MODE_QUERY, 127, -1, 1'b0);
    add_beat(MODE_UPDATE, 0, 8388607, 1'b0);
    add_beat(MODE_UPDATE, 127, -8388608, 1'b1);
    add_beat(MODE_QUERY, 0, 0, 1'b0);
    add_beat(MODE_UPDATE, 0, -8388608, 1'b0);
    add_beat(MODE_UPDATE, 127, 8388607, 1'b1);
    add_beat(MODE_ZSCORE, 0, 0, 1'b0);
    add_beat(MODE_QUERY, 127, 0, 1'b1);
    add_beat(MODE_ZSCORE, 0, 8388607, 1'b0);
    add_beat(MODE_ZSCORE, 127, -8388608, 1'b0);
    add_beat(MODE_CLEAR, 5, 1, 1'b1);
    for (i = 0; i < 3; i++) begin
      add_beat(MODE_UPDATE, 2, 5, 1'b0);
      add_beat(MODE_UPDATE, 3, i * 7 - 7, 1'b1);
    end
    add_beat(MODE_ZSCORE, 2, 9, 1'b0);
    add_beat(MODE_ZSCORE, 2, -9, 1'b0);
    add_beat(MODE_ZSCORE, 3, 1, 1'b0);
    drain;

    // range check and saturating flat z-score with one channel
    write_cfg(CFG_ACTIVE_CHANNELS, 1);
    write_cfg(CFG_ZERO_WHEN_FLAT, 0);
    add_beat(MODE_ZSCORE, 2, 9, 1'b0);
    add_beat(MODE_ZSCORE, 2, -9, 1'b0);
    add_beat(MODE_UPDATE, 1, 3, 1'b1);
    set_width = 1;
    random_phase(260);
    drain;

    write_cfg(CFG_ACTIVE_CHANNELS, 37);
    write_cfg(CFG_ZERO_WHEN_FLAT, 1);
    quiet = 1'b1;
    random_phase(270);
    drain;
    quiet = 1'b0;

    write_cfg(CFG_ACTIVE_CHANNELS, 128);
    write_cfg(CFG_ZERO_WHEN_FLAT, 0);
    random_phase(270);
    drain;

    write_cfg(CFG_ACTIVE_CHANNELS, 5);
    write_cfg(CFG_ZERO_WHEN_FLAT, 1);
    random_phase(270);
    drain;

    write_cfg(CFG_ACTIVE_CHANNELS, 128);
    random_phase(270);
    drain;

    tries = 0;
    while (tries < 400) begin
      @(posedge clk);
      tries++;
    end
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Verification failed");
    $finish;
  end
endmodule
